FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, round constants and helper functions shared by the hash core.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BlockBytesDefault = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        last_blk;
  } comp_ctrl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

FILE: rtl/sha_buf_mem.sv
// ----------------------------------------------------------------------------
// SHA-256 block buffer
// 16 x 32-bit word memory with byte write enables, registered read.
// ----------------------------------------------------------------------------
module sha_buf_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [3:0]  wbe,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < 4; b++) begin
        if (wbe[b]) mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
      end
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sha_round.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// One round per cycle; schedule window in a 16-entry register array, chain value in
// an 8-entry memory folded back after round 63.
// ----------------------------------------------------------------------------
module sha_round (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::comp_ctrl_t ctrl,
  output logic [3:0]          buf_raddr,
  input  logic [31:0]         buf_rdata,
  input  logic                hash_clear,
  input  logic [2:0]          hash_raddr,
  output logic [31:0]         hash_rdata,
  output logic                busy,
  output logic                done
);
  import sha_pkg::*;

  // chain value: valid bits give the initial constants until written
  logic [31:0] hmem [8];
  logic [7:0]  hvalid;
  logic [31:0] hq;
  logic [2:0]  hraddr_q;

  // rolling schedule window held in registers (read at several taps)
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [6:0]  t;     // 0..63 rounds, 64..72 fold (reads to 71, writes from 65)
  logic        run;
  logic        wait_rd;

  logic [31:0] wt, t1, t2, s0, s1;
  logic [3:0]  fidx;
  logic [31:0] fold_add;

  assign busy = run | wait_rd;
  assign buf_raddr = run ? t[3:0] + 4'd1 : 4'd0;

  always_comb begin
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    wt = (t < 7'd16) ? buf_rdata : s1 + w[9] + s0 + w[0];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(t[5:0]) + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    fidx = t[3:0] - 4'd1;
    unique case (fidx[2:0])
      3'd0: fold_add = a; 3'd1: fold_add = b; 3'd2: fold_add = c;
      3'd3: fold_add = d; 3'd4: fold_add = e; 3'd5: fold_add = f;
      3'd6: fold_add = g; default: fold_add = h;
    endcase
  end

  logic [2:0]  hidx;
  logic [31:0] hval;
  assign hidx = run ? t[2:0] : hash_raddr;

  always_ff @(posedge clk) begin
    hq <= hmem[hidx];
    hraddr_q <= hidx;
  end
  assign hval = hvalid[hraddr_q] ? hq : init_hash(hraddr_q);
  assign hash_rdata = hval;

  // sequence: start -> wait_rd (buf word0 read) -> 64 rounds -> fold
  // fold reads chain word k at t=64+k and writes it back in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; wait_rd <= 1'b0; t <= '0; hvalid <= '0; done <= 1'b0;
    end else begin
      done <= run && (t == 7'd72);
      if (hash_clear) hvalid <= '0;
      if (ctrl.start) begin
        wait_rd <= 1'b1; t <= '0;
      end else if (wait_rd) begin
        wait_rd <= 1'b0; run <= 1'b1;
      end else if (run) begin
        t <= t + 7'd1;
        if (t >= 7'd65) begin
          hmem[fidx[2:0]] <= hval + fold_add;
          hvalid[fidx[2:0]] <= 1'b1;
        end
        if (t == 7'd72) run <= 1'b0;
      end
    end
  end

  // working variables load from the chain value: a loaded during rounds
  // is impractical with one read port, so initial vars come from a shadow
  logic [31:0] init_v [8];
  always_ff @(posedge clk) begin
    if (run && t < 7'd64) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      h <= g; g <= f; f <= e; e <= d + t1; d <= c; c <= b; b <= a; a <= t1 + t2;
    end else if (ctrl.start) begin
      a <= init_v[0]; b <= init_v[1]; c <= init_v[2]; d <= init_v[3];
      e <= init_v[4]; f <= init_v[5]; g <= init_v[6]; h <= init_v[7];
    end
    if (rst || hash_clear) begin
      for (int i = 0; i < 8; i++) init_v[i] <= init_hash(3'(i));
    end else if (run && t >= 7'd65) begin
      init_v[fidx[2:0]] <= hval + fold_add;
    end
  end
endmodule

FILE: rtl/sha256_message_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message hash core
// Bytes are taken only while idle; the 64th byte of a block starts a
// compression (read, 64 rounds, fold of the 8 chain words, done).
// An end item pads one byte per cycle to the end of each final block, runs
// one or two compressions, then emits the 8 words one at a time.
// Input stalls while the one-round-per-cycle engine compresses a block.
// Synchronous reset returns chain value to the initial constants.
// ----------------------------------------------------------------------------
module sha256_message_hash_core #(
  parameter int BLOCK_BYTES = sha_pkg::BlockBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        stall_in,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word
);
  import sha_pkg::*;

  localparam int PW = $clog2(BLOCK_BYTES);

  state_t      state, state_next;
  logic [60:0] byte_count;
  logic [PW-1:0] pad_pos;
  logic        two_blk, last_blk;
  logic        cbusy, cdone, pend_last;
  logic        ended;
  logic [2:0]  oidx;
  logic [2:0]  oaddr;
  logic        oload;
  comp_ctrl_t  ctrl;

  logic        we;
  logic [3:0]  waddr, wbe, raddr;
  logic [31:0] wdata, rdata;
  logic [PW-1:0] rem;
  logic [63:0] bits;
  logic        acc;
  logic [7:0]  pb;
  logic [31:0] hrd;

  assign rem  = byte_count[PW-1:0];
  assign bits = {byte_count, 3'b000};
  assign acc  = valid_in && !stall_in;
  assign oaddr = (valid_out && !stall_out) ? oidx + 3'd1 : oidx;

  sha_buf_mem u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wbe(wbe), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  sha_round u_round (
    .clk(clk), .rst(rst), .ctrl(ctrl), .buf_raddr(raddr), .buf_rdata(rdata),
    .hash_clear(state == ST_OUT && oload && valid_out && !stall_out && final_word),
    .hash_raddr(oaddr), .hash_rdata(hrd), .busy(cbusy), .done(cdone)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc) begin
        if (byte_present && rem == PW'(BLOCK_BYTES - 1)) state_next = ST_COMP;
        else if (end_of_message) state_next = ST_PAD;
      end
      ST_PAD:  if (pad_pos == PW'(BLOCK_BYTES - 1)) state_next = ST_COMP;
      ST_COMP: if (cdone) begin
        if (!ended) state_next = ST_IDLE;
        else if (pend_last) state_next = ST_FOLD;
        else state_next = ST_PAD;
      end
      ST_FOLD: state_next = ST_OUT;
      ST_OUT:  if (valid_out && !stall_out && final_word) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // pad byte at pad_pos within the pad blocks
  always_comb begin
    pb = 8'h00;
    if (!two_blk || !last_blk) begin
      if (pad_pos == rem) pb = 8'h80;
    end
    if ((!two_blk || last_blk) && pad_pos >= PW'(BLOCK_BYTES - 8))
      pb = bits[(7 - 32'(pad_pos - PW'(BLOCK_BYTES - 8))) * 8 +: 8];
    if (two_blk && !last_blk && pad_pos < rem) pb = 8'h00;
  end

  always_comb begin
    we = 1'b0; waddr = '0; wbe = '0; wdata = '0;
    ctrl.start = 1'b0; ctrl.last_blk = last_blk;
    if (state == ST_IDLE && acc && byte_present) begin
      we = 1'b1; waddr = rem[PW-1:2]; wbe = 4'b1000 >> rem[1:0];
      wdata = {4{data_byte}};
    end
    if (state == ST_PAD && (two_blk && !last_blk ? pad_pos >= rem : pad_pos >= rem
        || two_blk)) begin
      we = 1'b1; waddr = pad_pos[PW-1:2]; wbe = 4'b1000 >> pad_pos[1:0];
      wdata = {4{pb}};
    end
    if ((state == ST_IDLE && acc && byte_present && rem == PW'(BLOCK_BYTES - 1)) ||
        (state == ST_PAD && pad_pos == PW'(BLOCK_BYTES - 1)))
      ctrl.start = 1'b1;
  end

  assign stall_in  = (state != ST_IDLE);
  assign valid_out = (state == ST_OUT) && oload;
  assign final_word = (oidx == 3'd7);
  assign word_index = oidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; byte_count <= '0; pad_pos <= '0; ended <= 1'b0;
      two_blk <= 1'b0; last_blk <= 1'b0; pend_last <= 1'b0; oidx <= '0;
      oload <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && acc) begin
        if (byte_present) byte_count <= byte_count + 61'd1;
        if (end_of_message) begin
          ended <= 1'b1;
          last_blk <= 1'b0;
          // full data block goes out first, then a pad block from byte 0
          if (byte_present && rem == PW'(BLOCK_BYTES - 1)) begin
            two_blk <= 1'b0; pad_pos <= '0; pend_last <= 1'b0;
          end else begin
            pad_pos <= byte_present ? rem + PW'(1) : rem;
            two_blk <= (byte_present ? rem + PW'(1) : rem) >= PW'(BLOCK_BYTES - 8);
            pend_last <= (byte_present ? rem + PW'(1) : rem) < PW'(BLOCK_BYTES - 8);
          end
        end
      end
      if (state == ST_PAD) pad_pos <= pad_pos + PW'(1);
      if (state == ST_COMP && cdone && ended && !pend_last) begin
        last_blk <= 1'b1; pend_last <= 1'b1; pad_pos <= '0;
      end
      if (state == ST_FOLD) begin
        oidx <= '0; oload <= 1'b0;
      end
      if (state == ST_OUT) begin
        if (!oload) oload <= 1'b1;
        else if (!stall_out) begin
          oload <= 1'b0;
          oidx <= oidx + 3'd1;
          if (final_word) begin
            byte_count <= '0; ended <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && !oload) digest_word <= hrd;
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    cbusy |-> stall_in) else $error("input taken during compression");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> !cbusy) else $error("output while compressing");
  a_final_ret: assert property (@(posedge clk) disable iff (rst)
    (valid_out && !stall_out && final_word) |=> state == ST_IDLE)
    else $error("no return to idle");
endmodule

FILE: tb/sha256_message_hash_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hash core testbench
// Streams messages byte by byte with random gaps and output stalls. A local
// SHA-256 model predicts the eight digest words of each message; the
// scoreboard checks every output transaction in order.
// ----------------------------------------------------------------------------
class digest_scoreboard;
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [60:0] nbytes;
  logic [31:0] exp_word[$];
  int          errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
    chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
    chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
    chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
    nbytes = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(t[5:0]) + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void note_input(logic [7:0] d, logic present, logic last);
    int rem;
    logic [63:0] bits;
    if (present) begin
      blk[nbytes[5:0]] = d;
      nbytes++;
      if (nbytes[5:0] == 0) compress();
    end
    if (!last) return;
    rem = nbytes[5:0];
    bits = {nbytes, 3'b000};
    blk[rem] = 8'h80;
    for (int i = rem + 1; i < 64; i++) blk[i] = 8'h00;
    if (rem >= 56) begin
      compress();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[56 + i] = bits[63 - 8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) exp_word.push_back(chain[i]);
    clear();
  endfunction

  function void check_output(logic [31:0] word, logic [2:0] idx, logic fin);
    logic [31:0] e;
    logic [2:0] ei;
    if (exp_word.size() == 0) begin
      $error("unexpected digest transaction %h", word);
      errors++;
      return;
    end
    ei = 3'(8 - exp_word.size() % 8);
    if (exp_word.size() % 8 == 0) ei = 3'd0;
    e = exp_word.pop_front();
    if (word !== e) begin
      $error("digest_word expected %h actual %h", e, word); errors++;
    end
    if (idx !== ei) begin
      $error("word_index expected %0d actual %0d", ei, idx); errors++;
    end
    if (fin !== (ei == 3'd7)) begin
      $error("final_word expected %0b actual %0b", ei == 3'd7, fin); errors++;
    end
  endfunction
endclass

module sha256_message_hash_core_tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid_in = 1'b0;
  logic        stall_in;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        valid_out;
  logic        stall_out = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  digest_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sha256_message_hash_core uut (
    .clk(clk), .rst(rst), .valid_in(valid_in), .stall_in(stall_in),
    .data_byte(data_byte), .byte_present(byte_present),
    .end_of_message(end_of_message), .valid_out(valid_out),
    .stall_out(stall_out), .digest_word(digest_word),
    .word_index(word_index), .final_word(final_word)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (valid_out && !stall_out) sb.check_output(digest_word, word_index, final_word);
      stall_out <= calm ? 1'b0 : ($urandom_range(99) < 36);
    end
    if (cycles > 600000) begin
      $display("sha256_message_hash_core: mismatch");
      $finish;
    end
  end

  task automatic send(logic [7:0] d, logic p, logic e);
    if (!calm)
      while ($urandom_range(99) < 36) begin
        valid_in <= 1'b0;
        @(posedge clk);
      end
    valid_in <= 1'b1;
    data_byte <= d;
    byte_present <= p;
    end_of_message <= e;
    do @(posedge clk); while (stall_in);
    sb.note_input(d, p, e);
  endtask

  task automatic message(int len, bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send(8'($urandom), 1'b0, 1'b0);
      send(8'($urandom), 1'b1, !bare_end && i == len - 1);
    end
    if (bare_end || len == 0) send(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    message(0, 1'b1);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b1);
    send(8'h5a, 1'b0, 1'b0);
    message(3, 1'b0);
    calm = 1'b1;
    message(55, 1'b0);
    message(56, 1'b0);
    calm = 1'b0;
    message(64, 1'b1);
    message(64, 1'b0);
    valid_in <= 1'b0;
    while (sb.exp_word.size() != 0) @(posedge clk);
    sent = 0;
    while (sent < 150) begin
      int len;
      case ($urandom_range(5))
        0: len = $urandom_range(3);
        1: len = 52 + $urandom_range(14);
        2: len = 64 + $urandom_range(70);
        default: len = $urandom_range(1, 40);
      endcase
      message(len, $urandom_range(3) == 0);
      sent += len + 1;
    end
    valid_in <= 1'b0;
    while (sb.exp_word.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.exp_word.size() == 0)
      $display("sha256_message_hash_core: match");
    else
      $display("sha256_message_hash_core: mismatch");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/sha_pkg.sv
rtl/sha_buf_mem.sv
rtl/sha_round.sv
rtl/sha256_message_hash_core.sv
tb/sha256_message_hash_core_tb.sv
